### sv/nec_pkg.sv
// Package for the normalized entropy (evenness) block.
// Holds payload structs, field widths and default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package nec_pkg;

  localparam int unsigned DEF_MAX_BINS      = 256;
  localparam int unsigned DEF_LOG_FRAC_BITS = 16;

  localparam int unsigned COUNT_W = 24;   // bin count width
  localparam int unsigned TOTAL_W = 32;   // running total T
  localparam int unsigned WSUM_W  = 56;   // running sum of s*log2(s)
  localparam int unsigned EVEN_W  = 16;   // Q1.15 result
  localparam int unsigned BINS_W  = 9;    // reported bin count

  localparam logic [EVEN_W-1:0] EVEN_ONE = 16'h8000;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic               last_item;
  } in_t;

  typedef struct packed {
    logic [EVEN_W-1:0] evenness;
    logic [BINS_W-1:0] bins_seen;
    logic              overflow;
  } out_t;

endpackage

### sv/normalized_entropy_of_counts.sv
// Normalized Shannon entropy of a stream of bin counts, iterative datapath.
// Depends on nec_pkg; one shared 32x32 multiplier and one shared subtractor.
//
//   Channel | Direction | Handshake              | Payload
//   in      | input     | in_valid_i / in_stall_o | in_data_i  (nec_pkg::in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (nec_pkg::out_t)
//
// Per bin: accept, then log2 via shift normalization (one bit per cycle
// plus a detect step), LOG_FRAC_BITS squaring steps, a result step and a
// multiply-accumulate step; a count of 0 or 1 skips the shifts and squaring.
// End of set adds log2(T), a 56-step restoring divide, log2(n) and a second
// 56-step divide, unless n is 0 or 1 or T is 0.
// Bins beyond MAX_BINS are dropped and set the overflow flag. in_stall_o is high whenever busy.
// The result sits in an output register until transferred; asynchronous reset.
`timescale 1ns / 1ps

module normalized_entropy_of_counts
  import nec_pkg::*;
#(
  parameter int unsigned MAX_BINS      = DEF_MAX_BINS,
  parameter int unsigned LOG_FRAC_BITS = DEF_LOG_FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned LFB = LOG_FRAC_BITS;
  localparam int unsigned LW  = 5 + LFB;                 // log2 result width
  localparam int unsigned NW  = $clog2(MAX_BINS + 1);    // bin counter width

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NORM  = 3'd1;
  localparam logic [2:0] S_SQR   = 3'd2;
  localparam logic [2:0] S_LDONE = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // what the current log2 / divide is for
  localparam logic [2:0] PH_BIN = 3'd0;
  localparam logic [2:0] PH_TOT = 3'd1;
  localparam logic [2:0] PH_DQ  = 3'd2;
  localparam logic [2:0] PH_N   = 3'd3;
  localparam logic [2:0] PH_DE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [2:0]         phase_q, phase_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [31:0]        m_q, m_d;
  logic [4:0]         msb_q, msb_d;
  logic [LFB-1:0]     frac_q, frac_d;
  logic               zero_q, zero_d;
  logic [COUNT_W-1:0] s_q, s_d;
  logic               last_q, last_d;
  logic [TOTAL_W-1:0] tot_q, tot_d;
  logic [WSUM_W-1:0]  wsum_q, wsum_d;
  logic [NW-1:0]      n_q, n_d;
  logic               ovf_q, ovf_d;
  logic [LW-1:0]      lt_q, lt_d;
  logic [LW-1:0]      h_q, h_d;
  logic [32:0]        rem_q, rem_d;
  logic [WSUM_W-1:0]  num_q, num_d;
  logic [31:0]        dvs_q, dvs_d;
  out_t               res_q, res_d;

  // shared multiplier
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [32:0]        sq_t;
  logic [LW-1:0]      lg;
  logic [WSUM_W:0]    wsum_sum;
  logic [TOTAL_W:0]   tot_sum;
  // shared subtractor (restoring divide step)
  logic [32:0]        rsh;
  logic               ge;
  logic [WSUM_W-1:0]  quot;
  // control helpers
  logic               log_start;
  logic [31:0]        log_x;
  logic               fin_go;
  logic [EVEN_W-1:0]  fin_ev;
  logic [NW+8:0]      n_ext;

  assign lg    = {msb_q, frac_q};
  assign mul_a = (state_q == S_MUL) ? {{(32-COUNT_W){1'b0}}, s_q} : m_q;
  assign mul_b = (state_q == S_MUL) ? {{(32-LW){1'b0}}, lg} : m_q;
  assign prod  = mul_a * mul_b;
  assign sq_t  = prod[63:31];

  assign wsum_sum = {1'b0, wsum_q} + {1'b0, prod[WSUM_W-1:0]};
  assign tot_sum  = {1'b0, tot_q} + {{(TOTAL_W+1-COUNT_W){1'b0}}, s_q};

  assign rsh  = {rem_q[31:0], num_q[WSUM_W-1]};
  assign ge   = rsh >= {1'b0, dvs_q};
  assign quot = {num_q[WSUM_W-2:0], ge};

  assign n_ext = {9'b0, n_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    msb_d   = msb_q;
    frac_d  = frac_q;
    zero_d  = zero_q;
    s_d     = s_q;
    last_d  = last_q;
    tot_d   = tot_q;
    wsum_d  = wsum_q;
    n_d     = n_q;
    ovf_d   = ovf_q;
    lt_d    = lt_q;
    h_d     = h_q;
    rem_d   = rem_q;
    num_d   = num_q;
    dvs_d   = dvs_q;
    res_d   = res_q;
    log_start = 1'b0;
    log_x     = '0;
    fin_go    = 1'b0;
    fin_ev    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          s_d    = in_data_i.bin_count;
          last_d = in_data_i.last_item;
          if (n_q >= NW'(MAX_BINS)) begin
            ovf_d   = 1'b1;
            state_d = in_data_i.last_item ? S_FIN : S_IDLE;
          end else begin
            log_start = 1'b1;
            log_x     = {{(32-COUNT_W){1'b0}}, in_data_i.bin_count};
            phase_d   = PH_BIN;
          end
        end
      end
      // shift the leading one up to bit 31
      S_NORM: begin
        if (zero_q) begin
          msb_d   = '0;
          state_d = S_LDONE;
        end else if (m_q[31]) begin
          cnt_d   = 6'(LFB - 1);
          state_d = S_SQR;
        end else begin
          m_d   = {m_q[30:0], 1'b0};
          msb_d = msb_q - 5'd1;
        end
      end
      // one fraction bit per squaring
      S_SQR: begin
        if (sq_t[32]) begin
          m_d    = sq_t[32:1];
          frac_d = {frac_q[LFB-2:0], 1'b1};
        end else begin
          m_d    = sq_t[31:0];
          frac_d = {frac_q[LFB-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) state_d = S_LDONE;
      end
      S_LDONE: begin
        unique case (phase_q)
          PH_BIN: state_d = S_MUL;
          PH_TOT: begin
            lt_d    = lg;
            num_d   = wsum_q;
            dvs_d   = tot_q;
            rem_d   = '0;
            cnt_d   = 6'(WSUM_W - 1);
            phase_d = PH_DQ;
            state_d = S_DIV;
          end
          PH_N: begin
            if (lg == '0) begin
              fin_go = 1'b1;
              fin_ev = EVEN_ONE;
            end else begin
              num_d   = {{(WSUM_W-LW-15){1'b0}}, h_q, 15'b0};
              dvs_d   = {{(32-LW){1'b0}}, lg};
              rem_d   = '0;
              cnt_d   = 6'(WSUM_W - 1);
              phase_d = PH_DE;
              state_d = S_DIV;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      // accumulate one bin with saturation
      S_MUL: begin
        wsum_d  = wsum_sum[WSUM_W] ? {WSUM_W{1'b1}} : wsum_sum[WSUM_W-1:0];
        tot_d   = tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0];
        n_d     = n_q + NW'(1);
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (n_q == NW'(1)) begin
          fin_go = 1'b1;
          fin_ev = EVEN_ONE;
        end else if (n_q == '0 || tot_q == '0) begin
          fin_go = 1'b1;
          fin_ev = '0;
        end else begin
          log_start = 1'b1;
          log_x     = tot_q;
          phase_d   = PH_TOT;
        end
      end
      // restoring divide, one quotient bit per cycle
      S_DIV: begin
        rem_d = ge ? (rsh - {1'b0, dvs_q}) : rsh;
        num_d = quot;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          if (phase_q == PH_DQ) begin
            h_d       = ({{(WSUM_W-LW){1'b0}}, lt_q} > quot)
                        ? (lt_q - quot[LW-1:0]) : '0;
            log_start = 1'b1;
            log_x     = {{(32-NW){1'b0}}, n_q};
            phase_d   = PH_N;
          end else begin
            fin_go = 1'b1;
            fin_ev = (quot > {{(WSUM_W-EVEN_W){1'b0}}, EVEN_ONE}) ? EVEN_ONE
                     : quot[EVEN_W-1:0];
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // load the log2 unit
    if (log_start) begin
      m_d     = log_x;
      msb_d   = 5'd31;
      frac_d  = '0;
      zero_d  = log_x <= 32'd1;
      state_d = S_NORM;
    end

    // capture the result and clear the set
    if (fin_go) begin
      res_d.evenness  = fin_ev;
      res_d.bins_seen = n_ext[8:0];
      res_d.overflow  = ovf_q;
      tot_d   = '0;
      wsum_d  = '0;
      n_d     = '0;
      ovf_d   = 1'b0;
      state_d = S_OUT;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_BIN;
      cnt_q   <= '0;
      tot_q   <= '0;
      wsum_q  <= '0;
      n_q     <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
      wsum_q  <= wsum_d;
      n_q     <= n_d;
      ovf_q   <= ovf_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    msb_q  <= msb_d;
    frac_q <= frac_d;
    zero_q <= zero_d;
    s_q    <= s_d;
    last_q <= last_d;
    lt_q   <= lt_d;
    h_q    <= h_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    dvs_q  <= dvs_d;
    res_q  <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

endmodule

### sv/nec_checker.sv
// Port-level checker for normalized_entropy_of_counts, bound to the top level.
// Depends on nec_pkg.
`timescale 1ns / 1ps

module nec_checker
  import nec_pkg::*;
#(
  parameter int unsigned MAX_BINS = DEF_MAX_BINS
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  localparam logic [BINS_W-1:0] MAX_SEEN = BINS_W'(MAX_BINS);

  // no input transfer while a result waits
  a_busy_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  // one result per set
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o) else $error("result repeated");

  // evenness never exceeds 1.0
  a_even_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.evenness <= EVEN_ONE) else $error("evenness > 1.0");

  // overflowed set reports the saturated count
  a_ovf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |-> out_data_o.bins_seen == MAX_SEEN)
    else $error("overflow without saturated bin count");

  // a result held under stall keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind normalized_entropy_of_counts nec_checker #(.MAX_BINS(MAX_BINS)) u_nec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
